// ----- src/vwd_pkg.sv -----
package vwd_pkg;

  localparam int MaxVertices = 4096;
  localparam int TableSlots  = 8192;
  localparam int SlotW       = $clog2(TableSlots);
  localparam int IdW         = 12;
  localparam int CountW      = $clog2(MaxVertices) + 1;
  localparam int KeyWords    = 4;
  localparam int KeyW        = 256;

  localparam logic [63:0] HashSeed = 64'h2545F4914F6CDD1D;
  localparam logic [63:0] HashMul  = 64'h9E3779B97F4A7C15;

  typedef struct packed {
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic        last_in_mesh;
  } vwd_in_t;

  typedef struct packed {
    logic [IdW-1:0] vertex_id;
    logic           is_new_vertex;
    logic           drop_triangle;
    logic           table_full;
  } vwd_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_XOR,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_READ,
    ST_CMP,
    ST_DONE,
    ST_OUT
  } vwd_state_e;

endpackage

// ----- src/vertex_weld_dedup.sv -----
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid_i/in_stall_o   | in_data_i  (vwd_in_t)
// out     | output    | out_valid_o/out_stall_i | out_data_o (vwd_out_t)
//
// After reset a clearing pass walks the whole slot valid table, one slot a
// cycle; no item is taken meanwhile.
// For the hash an item steps through 4 key words, each an XOR, a 64-bit
// multiply split into three 32x32 partial-product steps and a shift-mix;
// each probe of the slot memory is then a read and a compare step, and a
// done and an output step finish the item. Items are taken only in the
// idle state, so the next item waits until this one is through.
// A mesh end starts another clearing pass.
// The result waits in an output register; while a stalled result still sits
// there, the next result holds the block in its last step.
module vertex_weld_dedup
  import vwd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  vwd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output vwd_out_t out_data_o
);

  // Slot memories. The key and id arrays need no reset; valid bits are
  // cleared by the sweep.
  logic [KeyW-1:0] key_mem [TableSlots];
  logic [IdW-1:0]  id_mem  [TableSlots];
  logic            vld_mem [TableSlots];

  vwd_state_e state_q, state_d;

  vwd_in_t         item_q;
  logic [KeyW-1:0] key;
  logic [63:0]     h_q, h_d;
  logic [63:0]     acc_q, acc_d;
  logic [1:0]      word_q, word_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW:0]  probes_q, probes_d;
  logic [CountW-1:0] count_q, count_d;
  logic [1:0]      phase_q, phase_d;
  logic [IdW-1:0]  ear0_q, ear0_d, ear1_q, ear1_d;
  logic            out_valid_q;
  vwd_out_t        out_q, out_d;
  vwd_out_t        res_q, res_d;
  logic            load_out;

  logic [KeyW-1:0] rd_key_q;
  logic [IdW-1:0]  rd_id_q;
  logic            rd_vld_q;
  logic            wr_en;
  logic            clr_en;

  logic [63:0]     key_word;
  logic [IdW-1:0]  res_id;
  logic            res_new, res_full;

  logic [31:0]     mul_a, mul_b;
  logic [63:0]     mul_p;

  // Key is built as four 64-bit words: {pos_x,pos_y}, {pos_z,norm_x}, ...
  assign key = item_q[KeyW:1];

  always_comb begin
    case (word_q)
      2'd0:    key_word = key[255:192];
      2'd1:    key_word = key[191:128];
      2'd2:    key_word = key[127:64];
      default: key_word = key[63:0];
    endcase
  end

  // Operand select for the one shared 32x32 multiplier.
  always_comb begin
    mul_a = h_q[31:0];
    mul_b = HashMul[31:0];
    case (state_q)
      ST_MUL1: mul_b = HashMul[63:32];
      ST_MUL2: mul_a = h_q[63:32];
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Memory ports: one read and one write a cycle.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      rd_key_q <= key_mem[slot_q];
      rd_id_q  <= id_mem[slot_q];
      rd_vld_q <= vld_mem[slot_q];
    end
    if (clr_en) begin
      vld_mem[slot_q] <= 1'b0;
    end else if (wr_en) begin
      vld_mem[slot_q] <= 1'b1;
      key_mem[slot_q] <= key;
      id_mem[slot_q]  <= count_q[IdW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q <= in_data_i;
    end
    if (load_out) begin
      out_q <= out_d;
    end
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      h_q         <= '0;
      acc_q       <= '0;
      word_q      <= '0;
      slot_q      <= '0;
      probes_q    <= '0;
      count_q     <= '0;
      phase_q     <= '0;
      ear0_q      <= '0;
      ear1_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      h_q      <= h_d;
      acc_q    <= acc_d;
      word_q   <= word_d;
      slot_q   <= slot_d;
      probes_q <= probes_d;
      count_q  <= count_d;
      phase_q  <= phase_d;
      ear0_q   <= ear0_d;
      ear1_q   <= ear1_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (slot_q == SlotW'(TableSlots - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_XOR;
      ST_XOR:   state_d = ST_MUL0;
      ST_MUL0:  state_d = ST_MUL1;
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_MIX;
      ST_MIX:   state_d = (word_q == 2'd3) ? ST_READ : ST_XOR;
      ST_READ:  state_d = ST_CMP;
      ST_CMP: begin
        if (!rd_vld_q || rd_key_q == key) begin
          state_d = ST_DONE;
        end else if (probes_q == (SlotW+1)'(TableSlots - 1)) begin
          state_d = ST_DONE;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_DONE:  state_d = ST_OUT;
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = item_q.last_in_mesh ? ST_CLEAR : ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and output logic. The shared multiplier is one 32x32 product
  // per step: lo*lo, then the two cross terms in turn.
  always_comb begin
    h_d      = h_q;
    acc_d    = acc_q;
    word_d   = word_q;
    slot_d   = slot_q;
    probes_d = probes_q;
    count_d  = count_q;
    phase_d  = phase_q;
    ear0_d   = ear0_q;
    ear1_d   = ear1_q;
    wr_en    = 1'b0;
    clr_en   = 1'b0;
    load_out = 1'b0;
    res_id   = '0;
    res_new  = 1'b0;
    res_full = 1'b0;
    out_d    = out_q;
    res_d    = res_q;
    case (state_q)
      ST_CLEAR: begin
        clr_en = 1'b1;
        slot_d = slot_q + 1'b1;
        count_d = '0;
        phase_d = '0;
        ear0_d  = '0;
        ear1_d  = '0;
      end
      ST_IDLE: begin
        h_d    = HashSeed;
        word_d = '0;
      end
      ST_XOR: begin
        h_d = h_q ^ key_word;
      end
      ST_MUL0: begin
        acc_d = mul_p;
      end
      ST_MUL1: begin
        acc_d = acc_q + {mul_p[31:0], 32'd0};
      end
      ST_MUL2: begin
        acc_d = acc_q + {mul_p[31:0], 32'd0};
      end
      ST_MIX: begin
        h_d      = acc_q ^ (acc_q >> 29);
        word_d   = word_q + 1'b1;
        slot_d   = h_d[SlotW-1:0];
        probes_d = '0;
      end
      ST_CMP: begin
        if (!(!rd_vld_q || rd_key_q == key)) begin
          slot_d   = slot_q + 1'b1;
          probes_d = probes_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!rd_vld_q) begin
          if (count_q < CountW'(MaxVertices)) begin
            wr_en   = 1'b1;
            res_id  = count_q[IdW-1:0];
            res_new = 1'b1;
            count_d = count_q + 1'b1;
          end else begin
            res_full = 1'b1;
          end
        end else if (rd_key_q == key) begin
          res_id = rd_id_q;
        end else begin
          res_full = 1'b1;
        end
        res_d.vertex_id     = res_id;
        res_d.is_new_vertex = res_new;
        res_d.table_full    = res_full;
        res_d.drop_triangle = 1'b0;
        if (phase_q == 2'd2) begin
          res_d.drop_triangle = (res_id == ear0_q) || (res_id == ear1_q) ||
                                (ear0_q == ear1_q);
          phase_d = '0;
        end else begin
          if (phase_q == 2'd0) ear0_d = res_id;
          else                 ear1_d = res_id;
          phase_d = phase_q + 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          out_d    = res_q;
          slot_d   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
